>>> hw/rtl/rau_pkg.sv
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

    localparam int WORD_W = 32;
    localparam int MAG_W  = WORD_W + 1;
    localparam int WIDE_W = 2 * MAG_W;
    localparam int CNT_W  = $clog2(WIDE_W + 1);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_NEG = 3'd4;
    localparam logic [2:0] MODE_RCP = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIV0 = 2'd2;

    // Classified item handed from front to back.
    typedef struct packed {
        logic [2:0]       mode;
        logic             fail;
        logic             a_neg;
        logic [MAG_W-1:0] a_num;
        logic [MAG_W-1:0] a_den;
        logic             b_neg;
        logic [MAG_W-1:0] b_num;
        logic [MAG_W-1:0] b_den;
    } rau_cmd_t;

    localparam int CMD_W = $bits(rau_cmd_t);

    typedef struct packed {
        logic [WORD_W-1:0]   num;
        logic [WORD_W-2:0]   den;
        logic [1:0]          status;
    } rau_res_t;

endpackage

>>> hw/rtl/rau_front.sv
// Front end: takes operand transfers, forms magnitudes and flags zero divisors.
module rau_front
    import rau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             mode,
    input  logic signed [WORD_W-1:0] a_num,
    input  logic signed [WORD_W-1:0] a_den,
    input  logic signed [WORD_W-1:0] b_num,
    input  logic signed [WORD_W-1:0] b_den,
    output logic                   cmd_valid,
    input  logic                   cmd_ready,
    output rau_cmd_t               cmd
);

    rau_cmd_t cmd_next;
    logic     valid_reg;
    rau_cmd_t cmd_reg;

    function automatic logic [MAG_W-1:0] mag(input logic [WORD_W-1:0] v);
        logic [MAG_W-1:0] x;
        begin
            x = {1'b0, v};
            mag = v[WORD_W-1] ? (MAG_W'(0) - {1'b1, v}) : x;
        end
    endfunction

    always_comb
    begin
        cmd_next.mode  = mode;
        cmd_next.a_num = mag(a_num);
        cmd_next.a_den = mag(a_den);
        cmd_next.b_num = mag(b_num);
        cmd_next.b_den = mag(b_den);
        cmd_next.a_neg = a_num[WORD_W-1] ^ a_den[WORD_W-1];
        cmd_next.b_neg = b_num[WORD_W-1] ^ b_den[WORD_W-1];
        cmd_next.fail  = 1'b0;
        if (mode <= MODE_RCP)
        begin
            if (a_den == '0)
                cmd_next.fail = 1'b1;
            if (mode <= MODE_DIV && b_den == '0)
                cmd_next.fail = 1'b1;
            if (mode == MODE_DIV && b_num == '0)
                cmd_next.fail = 1'b1;
            if (mode == MODE_RCP && a_num == '0)
                cmd_next.fail = 1'b1;
        end
    end

    assign in_ready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cmd_reg <= cmd_next;
    end

endmodule

>>> hw/rtl/rau_divider.sv
// Restoring divider: one quotient bit per cycle on wide unsigned values.
module rau_divider
    import rau_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output logic              busy,
    output logic [WIDE_W-1:0] quot,
    output logic [WIDE_W-1:0] rem
);

    logic [WIDE_W-1:0] q_reg, r_reg, d_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [WIDE_W:0]   shifted;
    logic [WIDE_W:0]   diff;

    assign shifted = {r_reg, q_reg[WIDE_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(WIDE_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[WIDE_W])
            begin
                r_reg <= diff[WIDE_W-1:0];
                q_reg <= {q_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                r_reg <= shifted[WIDE_W-1:0];
                q_reg <= {q_reg[WIDE_W-2:0], 1'b0};
            end
        end
    end

    assign busy = busy_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

>>> hw/rtl/rau_back.sv
// Back end: cross products, gcd by repeated division, reduction and range check.
module rau_back
    import rau_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_ready,
    input  rau_cmd_t cmd,
    output logic     res_valid,
    input  logic     res_ready,
    output rau_res_t res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_LGCD  = 4'd1;
    localparam logic [3:0] S_LDIVA = 4'd2;
    localparam logic [3:0] S_LDIVB = 4'd3;
    localparam logic [3:0] S_PROD  = 4'd4;
    localparam logic [3:0] S_SUM   = 4'd5;
    localparam logic [3:0] S_GCD   = 4'd6;
    localparam logic [3:0] S_REDN  = 4'd7;
    localparam logic [3:0] S_REDD  = 4'd8;
    localparam logic [3:0] S_CHECK = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_WAIT  = 4'd11;
    localparam logic [3:0] S_XPROD = 4'd12;

    logic [3:0]        state_reg, ret_reg;
    rau_cmd_t          c_reg;
    logic [WIDE_W-1:0] x_reg, y_reg, num_reg, den_reg, ga_reg;
    logic [WIDE_W-1:0] ta_reg, tb_reg;
    logic              div_pend_reg;
    logic [MAG_W-1:0]  p0_reg, p1_reg;
    logic              neg_reg;
    rau_res_t          res_reg;
    logic              res_valid_reg;

    logic              dv_start, dv_busy;
    logic [WIDE_W-1:0] dv_a, dv_b, dv_q, dv_r;
    logic [WIDE_W-1:0] lim;
    logic [WIDE_W-1:0] ta, tb;
    logic              bneg;

    assign lim = WIDE_W'(1) << (WORD_W - 1);

    rau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_a),
        .divisor  (dv_b),
        .busy     (dv_busy),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    assign cmd_ready = (state_reg == S_IDLE) && !res_valid_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Cross products are 33x33, each registered before the sum.
    assign ta   = WIDE_W'(c_reg.a_num) * WIDE_W'(p0_reg);
    assign tb   = WIDE_W'(c_reg.b_num) * WIDE_W'(p1_reg);
    assign bneg = (c_reg.mode == MODE_SUB) ? !c_reg.b_neg : c_reg.b_neg;

    always_comb
    begin
        dv_start = 1'b0;
        dv_a     = x_reg;
        dv_b     = y_reg;
        unique case (state_reg)
            S_LDIVA: begin dv_a = WIDE_W'(c_reg.a_den); dv_b = ga_reg; end
            S_LDIVB: begin dv_a = WIDE_W'(c_reg.b_den); dv_b = ga_reg; end
            S_REDN:  begin dv_a = num_reg; dv_b = ga_reg; end
            S_REDD:  begin dv_a = den_reg; dv_b = ga_reg; end
            default: ;
        endcase
        if (!dv_busy && !div_pend_reg &&
            (state_reg == S_LDIVA || state_reg == S_LDIVB ||
             state_reg == S_REDN || state_reg == S_REDD ||
             ((state_reg == S_LGCD || state_reg == S_GCD) && y_reg != '0)))
            dv_start = 1'b1;
    end

    // div_pend_reg marks a divide issued; wait for it to finish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            div_pend_reg  <= 1'b0;
            ret_reg       <= S_IDLE;
        end
        else
        begin
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        c_reg <= cmd;
                        if (cmd.mode > MODE_RCP)
                        begin
                            res_reg   <= '{num: '0, den: (WORD_W-1)'(1), status: ST_OK};
                            state_reg <= S_OUT;
                        end
                        else if (cmd.fail)
                        begin
                            res_reg   <= '{num: '0, den: '0, status: ST_DIV0};
                            state_reg <= S_OUT;
                        end
                        else if (cmd.mode == MODE_ADD || cmd.mode == MODE_SUB)
                        begin
                            x_reg     <= WIDE_W'(cmd.a_den);
                            y_reg     <= WIDE_W'(cmd.b_den);
                            state_reg <= S_LGCD;
                        end
                        else
                            state_reg <= S_PROD;
                    end
                end
                S_LGCD, S_GCD:
                begin
                    if (div_pend_reg)
                    begin
                        if (!dv_busy)
                        begin
                            div_pend_reg <= 1'b0;
                            x_reg        <= y_reg;
                            y_reg        <= dv_r;
                        end
                    end
                    else if (y_reg == '0)
                    begin
                        ga_reg    <= x_reg;
                        state_reg <= (state_reg == S_LGCD) ? S_LDIVA :
                                     ((x_reg == '0) ? S_CHECK : S_REDN);
                    end
                    else
                        div_pend_reg <= 1'b1;
                end
                S_LDIVA, S_LDIVB, S_REDN, S_REDD:
                begin
                    if (!div_pend_reg)
                        div_pend_reg <= 1'b1;
                    else if (!dv_busy)
                    begin
                        div_pend_reg <= 1'b0;
                        unique case (state_reg)
                            S_LDIVA: begin p1_reg <= dv_q[MAG_W-1:0]; state_reg <= S_LDIVB; end
                            S_LDIVB: begin p0_reg <= dv_q[MAG_W-1:0]; state_reg <= S_XPROD; end
                            S_REDN:  begin num_reg <= dv_q; state_reg <= S_REDD; end
                            default: begin den_reg <= dv_q; state_reg <= S_CHECK; end
                        endcase
                    end
                end
                S_XPROD:
                begin
                    // l = (a_den/g) * b_den
                    den_reg   <= WIDE_W'(p1_reg) * WIDE_W'(c_reg.b_den);
                    ta_reg    <= ta;
                    tb_reg    <= tb;
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    if (c_reg.a_neg == bneg)
                    begin
                        neg_reg <= c_reg.a_neg;
                        num_reg <= ta_reg + tb_reg;
                    end
                    else if (ta_reg >= tb_reg)
                    begin
                        neg_reg <= c_reg.a_neg;
                        num_reg <= ta_reg - tb_reg;
                    end
                    else
                    begin
                        neg_reg <= bneg;
                        num_reg <= tb_reg - ta_reg;
                    end
                    ret_reg   <= S_GCD;
                    state_reg <= S_WAIT;
                end
                S_PROD:
                begin
                    unique case (c_reg.mode)
                        MODE_MUL:
                        begin
                            neg_reg <= c_reg.a_neg ^ c_reg.b_neg;
                            num_reg <= WIDE_W'(c_reg.a_num) * WIDE_W'(c_reg.b_num);
                            den_reg <= WIDE_W'(c_reg.a_den) * WIDE_W'(c_reg.b_den);
                        end
                        MODE_DIV:
                        begin
                            neg_reg <= c_reg.a_neg ^ c_reg.b_neg;
                            num_reg <= WIDE_W'(c_reg.a_num) * WIDE_W'(c_reg.b_den);
                            den_reg <= WIDE_W'(c_reg.a_den) * WIDE_W'(c_reg.b_num);
                        end
                        MODE_NEG:
                        begin
                            neg_reg <= !c_reg.a_neg;
                            num_reg <= WIDE_W'(c_reg.a_num);
                            den_reg <= WIDE_W'(c_reg.a_den);
                        end
                        default:
                        begin
                            neg_reg <= c_reg.a_neg;
                            num_reg <= WIDE_W'(c_reg.a_den);
                            den_reg <= WIDE_W'(c_reg.a_num);
                        end
                    endcase
                    ret_reg   <= S_GCD;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    x_reg     <= num_reg;
                    y_reg     <= den_reg;
                    state_reg <= ret_reg;
                end
                S_CHECK:
                begin
                    if (num_reg == '0)
                        res_reg <= '{num: '0, den: (WORD_W-1)'(1), status: ST_OK};
                    else if (den_reg > lim - 1'b1 ||
                             (neg_reg ? num_reg > lim : num_reg > lim - 1'b1))
                        res_reg <= '{num: '0, den: '0, status: ST_OVF};
                    else
                        res_reg <= '{num: neg_reg ? WORD_W'(WIDE_W'(0) - num_reg)
                                                  : num_reg[WORD_W-1:0],
                                     den: den_reg[WORD_W-2:0], status: ST_OK};
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    res_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.status <= ST_DIV0)
        else $error("bad status code");
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != ST_OK |-> res.num == '0 && res.den == '0)
        else $error("failed result carries data");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_ready |-> !dv_busy)
        else $error("divider busy while idle");

endmodule

>>> hw/rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: front end, one-entry queue, back end.
// An error or unused mode skips the gcd and the divides; otherwise each gcd
// remainder step and each reduction divide runs a full restoring division on
// 66-bit values plus issue and capture.
// Throughput: one item at a time in the back end; the front holds one more.
// Reset: rst_n asynchronous active low clears all valid flags and state.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den (from bit 0)
    input  logic [2:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // res_num, res_den, status (from bit 0)
);

    logic     cmd_valid, cmd_ready;
    rau_cmd_t cmd;
    rau_res_t res;

    rau_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .mode      (s_axis_tuser),
        .a_num     (s_axis_tdata[31:0]),
        .a_den     (s_axis_tdata[63:32]),
        .b_num     (s_axis_tdata[95:64]),
        .b_den     (s_axis_tdata[127:96]),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rau_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tdata = {7'd0, res.status, res.den, res.num};

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the rational arithmetic unit with a gcd-reduction predictor.
`timescale 1ns / 1ps

module tb_top
    import rau_pkg::*;
();

    localparam logic [2:0] MODE_RSV6 = 3'd6;
    localparam logic [2:0] MODE_RSV7 = 3'd7;
    localparam int N_RANDOM  = 900;
    localparam int QUIET_AT  = 800;
    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    typedef struct {
        logic [31:0] num;
        logic [30:0] den;
        logic [1:0]  status;
    } frac_res_t;

    // Exact rational result, reduced, with the unit's status codes.
    class frac_scoreboard;
        frac_res_t pending_q[$];
        int        errors;

        function new();
            errors = 0;
        endfunction

        function logic [63:0] magnitude(input logic [31:0] v);
            return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        endfunction

        function logic [63:0] gcd(input logic [63:0] x, input logic [63:0] y);
            logic [63:0] t;
            while (y != 0)
            begin
                t = x % y;
                x = y;
                y = t;
            end
            return x;
        endfunction

        function frac_res_t reduce(input logic neg, input logic [63:0] n, input logic [63:0] d);
            frac_res_t r;
            logic [63:0] g;
            logic [63:0] lim;
            g   = gcd(n, d);
            lim = 64'd1 << 31;
            if (g != 0)
            begin
                n = n / g;
                d = d / g;
            end
            if (n == 0)
            begin
                neg = 1'b0;
                d   = 1;
            end
            if (d > lim - 1 || (neg ? n > lim : n > lim - 1))
            begin
                r.num = '0;
                r.den = '0;
                r.status = ST_OVF;
            end
            else
            begin
                r.num = neg ? 32'(64'd0 - n) : n[31:0];
                r.den = d[30:0];
                r.status = ST_OK;
            end
            return r;
        endfunction

        function frac_res_t error_res(input logic [1:0] st);
            frac_res_t r;
            r.num = '0;
            r.den = '0;
            r.status = st;
            return r;
        endfunction

        function frac_res_t compute(input logic [2:0] mode, input logic [31:0] an,
                                    input logic [31:0] ad, input logic [31:0] bn,
                                    input logic [31:0] bd);
            logic [63:0] anm, adm, bnm, bdm, g, l, ta, tb, r;
            logic a_neg, b_neg, bs, rn;
            anm = magnitude(an);
            adm = magnitude(ad);
            bnm = magnitude(bn);
            bdm = magnitude(bd);
            a_neg = an[31] != ad[31];
            b_neg = bn[31] != bd[31];
            if (mode > MODE_RCP)
                return reduce(1'b0, 64'd0, 64'd1);
            if (adm == 0)
                return error_res(ST_DIV0);
            if (mode <= MODE_DIV && bdm == 0)
                return error_res(ST_DIV0);
            case (mode)
                MODE_ADD, MODE_SUB:
                begin
                    g  = gcd(adm, bdm);
                    l  = (adm / g) * bdm;
                    ta = anm * (bdm / g);
                    tb = bnm * (adm / g);
                    bs = (mode == MODE_SUB) ? !b_neg : b_neg;
                    if (a_neg == bs)
                    begin
                        rn = a_neg;
                        r  = ta + tb;
                    end
                    else if (ta >= tb)
                    begin
                        rn = a_neg;
                        r  = ta - tb;
                    end
                    else
                    begin
                        rn = bs;
                        r  = tb - ta;
                    end
                    return reduce(rn, r, l);
                end
                MODE_MUL: return reduce(a_neg != b_neg, anm * bnm, adm * bdm);
                MODE_DIV:
                begin
                    if (bnm == 0)
                        return error_res(ST_DIV0);
                    return reduce(a_neg != b_neg, anm * bdm, adm * bnm);
                end
                MODE_NEG: return reduce(!a_neg, anm, adm);
                default:
                begin
                    if (anm == 0)
                        return error_res(ST_DIV0);
                    return reduce(a_neg, adm, anm);
                end
            endcase
        endfunction

        function void note_input(input logic [2:0] mode, input logic [31:0] an,
                                 input logic [31:0] ad, input logic [31:0] bn,
                                 input logic [31:0] bd);
            pending_q.push_back(compute(mode, an, ad, bn, bd));
        endfunction

        function void check_result(input logic [71:0] data);
            frac_res_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, data);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (data[31:0] !== e.num)
            begin
                $display("%0t: res_num expected %h actual %h", $realtime, e.num, data[31:0]);
                errors++;
            end
            if (data[62:32] !== e.den)
            begin
                $display("%0t: res_den expected %h actual %h", $realtime, e.den, data[62:32]);
                errors++;
            end
            if (data[64:63] !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $realtime, e.status,
                         data[64:63]);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;  // a_num, a_den, b_num, b_den (from bit 0)
    logic [2:0]   s_axis_tuser;  // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [71:0]  m_axis_tdata;  // res_num, res_den, status (from bit 0)

    frac_scoreboard sb = new();
    bit     quiet;
    int     stall_left;
    longint cycles;

    rational_arithmetic_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        quiet = 1'b0;
        stall_left = 0;
        cycles = 0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: check each transfer, stall in random bursts.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left <= stall_left - 1;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 5);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [31:0] an,
                             input logic [31:0] ad, input logic [31:0] bn,
                             input logic [31:0] bd);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {bd, bn, ad, an};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(mode, an, ad, bn, bd);
    endtask

    function automatic logic [31:0] pick_value(input bit nonzero);
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = 32'($signed($urandom_range(0, 40)) - 20);
            4, 5:       v = 32'($signed($urandom_range(0, 65535)) - 32768);
            6, 7:       v = $urandom();
            default:
                case ($urandom_range(0, 4))
                    0: v = 32'd0;
                    1: v = 32'd1;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
        endcase
        if (nonzero && v == 0)
            v = 32'd1 + $urandom_range(0, 6);
        return v;
    endfunction

    initial
    begin
        logic [2:0] m;
        bit nz;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_item(MODE_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
        send_item(MODE_MUL, 32'hFFFF_FFFE, 32'd3, 32'd3, 32'hFFFF_FFFC);
        send_item(MODE_DIV, 32'd5, 32'd7, 32'hFFFF_FFF6, 32'd14);
        send_item(MODE_NEG, 32'd6, 32'hFFFF_FFF7, 32'd0, 32'd0);
        send_item(MODE_RCP, 32'hFFFF_FFFD, 32'd9, 32'd0, 32'd0);
        // zero denominators and zero divisors
        send_item(MODE_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
        send_item(MODE_MUL, 32'd1, 32'd1, 32'd1, 32'd0);
        send_item(MODE_NEG, 32'd1, 32'd0, 32'd5, 32'd5);
        send_item(MODE_DIV, 32'd3, 32'd4, 32'd0, 32'd9);
        send_item(MODE_RCP, 32'd0, 32'd4, 32'd1, 32'd1);
        send_item(MODE_NEG, 32'd4, 32'd7, 32'd0, 32'd0);
        // range extremes and overflow
        send_item(MODE_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd1);
        send_item(MODE_RCP, 32'd1, 32'h8000_0000, 32'd0, 32'd1);
        send_item(MODE_NEG, 32'd3, 32'h8000_0000, 32'd0, 32'd1);
        send_item(MODE_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(MODE_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1);
        send_item(MODE_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_item(MODE_ADD, 32'd1, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFE);
        send_item(MODE_DIV, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(MODE_SUB, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd5);
        // unused modes give 0/1 whatever the operands
        send_item(MODE_RSV6, 32'd0, 32'd0, 32'd0, 32'd0);
        send_item(MODE_RSV7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == QUIET_AT)
                quiet = 1'b1;
            m = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
                3'($urandom_range(0, 5));
            nz = $urandom_range(0, 15) != 0;
            send_item(m, pick_value(1'b0), pick_value(nz), pick_value(1'b0), pick_value(nz));
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
